[rtl/ucb_bandit_channel_selector_top_assert.svh]
`ifndef UCB_BANDIT_CHANNEL_SELECTOR_TOP_ASSERT_SVH
`define UCB_BANDIT_CHANNEL_SELECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define UCBCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UCBCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ucbcs_pkg.sv]
package ucbcs_pkg;

    localparam int NUM_ARMS  = 4;
    localparam int ARM_W     = 2;
    localparam int CNT_W     = 24;
    localparam int PROB_W    = 16;
    localparam int K_W       = 2;
    localparam int TOT_W     = 32;
    localparam int FRAC_W    = 20;
    localparam int DIVD_W    = CNT_W + FRAC_W;
    localparam int DIVS_W    = CNT_W;
    localparam int SQ_W      = 24;
    localparam int IDX_W     = CNT_W + 1;
    localparam int STEP_W    = 5;
    localparam int LN_STEPS  = 20;
    localparam int MUL_STEPS = 9;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 48;

    localparam logic [CNT_W-1:0]  Q20_MAX = 24'hFFFFFF;
    localparam logic [31:0]       LN2_Q30 = 32'd744261118;

    localparam logic [PROB_W-1:0] PROB0_RST = 16'd6554;
    localparam logic [PROB_W-1:0] PROB1_RST = 16'd19661;
    localparam logic [PROB_W-1:0] PROB2_RST = 16'd32768;
    localparam logic [PROB_W-1:0] PROB3_RST = 16'd45875;
    localparam logic [K_W-1:0]    K_RST     = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARM0    = 3'd0,
        CFG_ARM1    = 3'd1,
        CFG_ARM2    = 3'd2,
        CFG_ARM3    = 3'd3,
        CFG_MAX_OCC = 3'd4
    } t_cfg_idx;

    typedef enum logic [STEP_W-1:0] {
        MUL_M12 = 5'd0,
        MUL_M13 = 5'd1,
        MUL_M14 = 5'd2,
        MUL_M23 = 5'd3,
        MUL_M24 = 5'd4,
        MUL_M34 = 5'd5,
        MUL_S1  = 5'd6,
        MUL_T1  = 5'd7,
        MUL_T2  = 5'd8
    } t_mul_step;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LN_INIT,
        OP_LN_SQ,
        OP_LN_SCALE,
        OP_DIV_W,
        OP_STORE_W,
        OP_DIV_L,
        OP_SQRT,
        OP_STORE_IDX,
        OP_SORT,
        OP_MUL,
        OP_CHOOSE,
        OP_FINISH
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LN_INIT,
        ST_LN_SQ,
        ST_LN_SCALE,
        ST_DIV_W,
        ST_WAIT_W,
        ST_DIV_L,
        ST_WAIT_L,
        ST_WAIT_SQ,
        ST_SORT,
        ST_MUL,
        ST_CHOOSE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [ARM_W-1:0]  arm;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic warm;
        logic div_done;
        logic sqrt_done;
    } t_sts;

endpackage

[rtl/ucbcs_div.sv]
module ucbcs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ucbcs_pkg::DIVD_W-1:0] i_dividend,
    input  logic [ucbcs_pkg::DIVS_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [ucbcs_pkg::DIVD_W-1:0] o_quotient
);
    import ucbcs_pkg::*;

    localparam int CW = $clog2(DIVD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_den;
    logic [DIVS_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DIVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIVS_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIVS_W-1:0];
            end
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/ucbcs_sqrt.sv]
module ucbcs_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ucbcs_pkg::DIVD_W-1:0] i_value,
    output logic                         o_done,
    output logic [ucbcs_pkg::SQ_W-1:0]   o_root
);
    import ucbcs_pkg::*;

    localparam int WW    = 2 * ((DIVD_W + 1) / 2) + 4;
    localparam int STEPS = WW / 2;
    localparam int CW    = $clog2(STEPS);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [WW-1:0] r_v, r_res, r_bit;
    logic [WW-1:0] trial;

    assign trial = r_res + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= WW'(i_value);
            r_res <= '0;
            r_bit <= WW'(1) << (WW - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[SQ_W-1:0];

endmodule

[rtl/ucbcs_dp.sv]
module ucbcs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ucbcs_pkg::t_cmd                 i_cmd,
    output ucbcs_pkg::t_sts                 o_sts,
    input  logic [ucbcs_pkg::IN_W-1:0]      i_sample,
    input  logic                            i_cfg_valid,
    input  logic [ucbcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ucbcs_pkg::PROB_W-1:0]    i_cfg_data,
    output logic [ucbcs_pkg::OUT_W-1:0]     o_tdata
);
    import ucbcs_pkg::*;

    logic [PROB_W-1:0] r_prob [NUM_ARMS];
    logic [K_W-1:0]    r_k;
    logic [CNT_W-1:0]  r_succ [NUM_ARMS];
    logic [CNT_W-1:0]  r_trial [NUM_ARMS];
    logic [CNT_W-1:0]  r_round;
    logic              r_toggle;
    logic [TOT_W-1:0]  r_total;

    logic [IN_W-1:0]   r_sample;
    logic [4:0]        r_e;
    logic [31:0]       r_y;
    logic [FRAC_W-1:0] r_frac;
    logic              r_small;
    logic [CNT_W-1:0]  r_ln;
    logic [CNT_W-1:0]  r_w [NUM_ARMS];
    logic [IDX_W-1:0]  r_idx [NUM_ARMS];
    logic [CNT_W-1:0]  r_ws [NUM_ARMS];
    logic [ARM_W-1:0]  r_rank [NUM_ARMS];
    logic [27:0]       r_m12, r_m34;
    logic [35:0]       r_s1;
    logic [30:0]       r_s2;
    logic [34:0]       r_s3;
    logic [2:0]        r_arms;
    logic [3:0]        r_o_sel, r_o_rew;
    logic [2:0]        r_o_arms, r_o_vac;

    logic              div_start, div_done, sqrt_done;
    logic [DIVD_W-1:0] div_dividend, div_quo;
    logic [DIVS_W-1:0] div_divisor, trial_sel;
    logic [SQ_W-1:0]   root;

    logic [1:0]        k_eff;
    logic              warm;
    logic [4:0]        e_cmb;
    logic [53:0]       ln_wide;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [43:0]       prod_sh;
    logic [31:0]       sq;
    logic [24:0]       ln_l;
    logic [ARM_W-1:0]  rank_w [NUM_ARMS];
    logic [ARM_W-1:0]  rank_i [NUM_ARMS];
    logic [24:0]       p1;
    logic [25:0]       p2;
    logic signed [40:0] p1s, p2s, p3s;
    logic [2:0]        arms_ch;
    logic [2:0]        arms_fin;
    logic [3:0]        sel_fin, rew_raw, rew_fin;
    logic [2:0]        vac_raw, vac_fin, miss;
    logic [TOT_W:0]    total_sum;

    assign k_eff = (r_k == 2'd0) ? 2'd1 : ((r_k == 2'd3) ? 2'd2 : r_k);
    assign warm  = (k_eff == 2'd1) ? (r_round < CNT_W'(NUM_ARMS)) :
                                     (r_round < CNT_W'(NUM_ARMS / 2));

    assign trial_sel    = r_trial[i_cmd.arm];
    assign div_start    = (i_cmd.op == OP_DIV_W) || (i_cmd.op == OP_DIV_L);
    assign div_divisor  = (trial_sel == '0) ? DIVS_W'(1) : trial_sel;
    assign div_dividend = (i_cmd.op == OP_DIV_W) ? {r_succ[i_cmd.arm], FRAC_W'(0)} :
                                                   {r_ln, FRAC_W'(0)};

    ucbcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    ucbcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_value (div_quo),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    always_comb begin
        e_cmb = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (r_round[i]) begin
                e_cmb = 5'(i);
            end
        end
    end
    assign ln_wide = (54'(r_round) << 30) >> e_cmb;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_LN_SQ: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            OP_LN_SCALE: begin
                mul_a = 32'({r_e, r_frac});
                mul_b = LN2_Q30;
            end
            OP_MUL: begin
                case (i_cmd.step)
                    MUL_M12: begin mul_a = 32'(r_ws[0]); mul_b = 32'(r_ws[1]); end
                    MUL_M13: begin mul_a = 32'(r_ws[0]); mul_b = 32'(r_ws[2]); end
                    MUL_M14: begin mul_a = 32'(r_ws[0]); mul_b = 32'(r_ws[3]); end
                    MUL_M23: begin mul_a = 32'(r_ws[1]); mul_b = 32'(r_ws[2]); end
                    MUL_M24: begin mul_a = 32'(r_ws[1]); mul_b = 32'(r_ws[3]); end
                    MUL_M34: begin mul_a = 32'(r_ws[2]); mul_b = 32'(r_ws[3]); end
                    MUL_S1:  begin mul_a = 32'(r_m12);   mul_b = 32'(r_m34);   end
                    MUL_T1: begin
                        mul_a = 32'(r_m12);
                        mul_b = 32'({1'b0, r_ws[2]} + {1'b0, r_ws[3]});
                    end
                    MUL_T2: begin
                        mul_a = 32'(r_m34);
                        mul_b = 32'({1'b0, r_ws[0]} + {1'b0, r_ws[1]});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = 64'(mul_a) * 64'(mul_b);
    assign prod_sh = prod[63:20];
    assign sq      = prod[61:30];
    assign ln_l    = prod[54:30];

    always_comb begin
        for (int a = 0; a < NUM_ARMS; a++) begin
            rank_w[a] = '0;
            rank_i[a] = '0;
            for (int b = 0; b < NUM_ARMS; b++) begin
                if (b != a) begin
                    if ((r_w[b] > r_w[a]) || ((r_w[b] == r_w[a]) && (b < a))) begin
                        rank_w[a] = rank_w[a] + 1'b1;
                    end
                    if ((r_idx[b] > r_idx[a]) || ((r_idx[b] == r_idx[a]) && (b < a))) begin
                        rank_i[a] = rank_i[a] + 1'b1;
                    end
                end
            end
        end
    end

    assign p1  = {1'b0, r_ws[0]} + {1'b0, r_ws[1]};
    assign p2  = {1'b0, p1} + 26'(r_ws[2]);
    assign p1s = $signed(41'(p1));
    assign p2s = $signed(41'(p2));
    assign p3s = $signed(41'(r_s1) << 2) + $signed(41'(r_s2) << 1)
               - $signed(41'(r_s3)) - $signed(41'(r_s3) << 1);

    always_comb begin
        if ((p1s >= p2s) && (p1s >= p3s)) begin
            arms_ch = 3'd2;
        end else if ((p2s >= p1s) && (p2s >= p3s)) begin
            arms_ch = 3'd3;
        end else begin
            arms_ch = 3'd4;
        end
    end

    always_comb begin
        if (warm) begin
            arms_fin = 3'(k_eff);
            if (r_toggle) begin
                sel_fin = (k_eff == 2'd1) ? 4'b0001 : 4'b0011;
            end else begin
                sel_fin = (k_eff == 2'd1) ? 4'b0100 : 4'b1100;
            end
        end else begin
            arms_fin = r_arms;
            for (int a = 0; a < NUM_ARMS; a++) begin
                sel_fin[a] = {1'b0, r_rank[a]} < r_arms;
            end
        end
        vac_raw = '0;
        for (int a = 0; a < NUM_ARMS; a++) begin
            rew_raw[a] = sel_fin[a] && (r_sample < r_prob[a]);
            vac_raw    = vac_raw + 3'(rew_raw[a]);
        end
        miss = arms_fin - vac_raw;
        if (miss > 3'(k_eff)) begin
            rew_fin = '0;
            vac_fin = '0;
        end else begin
            rew_fin = rew_raw;
            vac_fin = vac_raw;
        end
        total_sum = {1'b0, r_total} + 33'(vac_fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob[0] <= PROB0_RST;
            r_prob[1] <= PROB1_RST;
            r_prob[2] <= PROB2_RST;
            r_prob[3] <= PROB3_RST;
            r_k       <= K_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ARM0:    r_prob[0] <= i_cfg_data;
                CFG_ARM1:    r_prob[1] <= i_cfg_data;
                CFG_ARM2:    r_prob[2] <= i_cfg_data;
                CFG_ARM3:    r_prob[3] <= i_cfg_data;
                CFG_MAX_OCC: r_k       <= i_cfg_data[K_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_ARMS; a++) begin
                r_succ[a]  <= CNT_W'(1);
                r_trial[a] <= CNT_W'(1);
            end
            r_round  <= '0;
            r_toggle <= 1'b1;
            r_total  <= '0;
        end else if (i_cmd.op == OP_FINISH) begin
            for (int a = 0; a < NUM_ARMS; a++) begin
                if (rew_fin[a] && (r_succ[a] != Q20_MAX)) begin
                    r_succ[a] <= r_succ[a] + 1'b1;
                end
                if (sel_fin[a] && (r_trial[a] != Q20_MAX)) begin
                    r_trial[a] <= r_trial[a] + 1'b1;
                end
            end
            if (r_round != Q20_MAX) begin
                r_round <= r_round + 1'b1;
            end
            if (warm) begin
                r_toggle <= !r_toggle;
            end
            r_total <= total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: r_sample <= i_sample;
            OP_LN_INIT: begin
                r_e     <= e_cmb;
                r_y     <= ln_wide[31:0];
                r_frac  <= '0;
                r_small <= r_round <= CNT_W'(1);
            end
            OP_LN_SQ: begin
                if (sq[31]) begin
                    r_y    <= sq >> 1;
                    r_frac <= {r_frac[FRAC_W-2:0], 1'b1};
                end else begin
                    r_y    <= sq;
                    r_frac <= {r_frac[FRAC_W-2:0], 1'b0};
                end
            end
            OP_LN_SCALE: begin
                if (r_small) begin
                    r_ln <= '0;
                end else if (ln_l[24]) begin
                    r_ln <= Q20_MAX;
                end else begin
                    r_ln <= ln_l[CNT_W-1:0];
                end
            end
            OP_STORE_W: begin
                r_w[i_cmd.arm] <= (|div_quo[DIVD_W-1:CNT_W]) ? Q20_MAX : div_quo[CNT_W-1:0];
            end
            OP_STORE_IDX: begin
                r_idx[i_cmd.arm] <= {1'b0, r_w[i_cmd.arm]} + IDX_W'(root);
            end
            OP_SORT: begin
                for (int a = 0; a < NUM_ARMS; a++) begin
                    r_ws[rank_w[a]] <= r_w[a];
                    r_rank[a]       <= rank_i[a];
                end
            end
            OP_MUL: begin
                case (i_cmd.step)
                    MUL_M12: begin
                        r_m12 <= prod_sh[27:0];
                        r_s2  <= 31'(prod_sh[27:0]);
                    end
                    MUL_M34: begin
                        r_m34 <= prod_sh[27:0];
                        r_s2  <= r_s2 + 31'(prod_sh[27:0]);
                    end
                    MUL_S1: r_s1 <= prod_sh[35:0];
                    MUL_T1: r_s3 <= 35'(prod_sh[33:0]);
                    MUL_T2: r_s3 <= r_s3 + 35'(prod_sh[33:0]);
                    default: r_s2 <= r_s2 + 31'(prod_sh[27:0]);
                endcase
            end
            OP_CHOOSE: r_arms <= arms_ch;
            OP_FINISH: begin
                r_o_sel  <= sel_fin;
                r_o_rew  <= rew_fin;
                r_o_arms <= arms_fin;
                r_o_vac  <= vac_fin;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.warm      = warm;
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;

    assign o_tdata = {2'b00, r_total, r_o_vac, r_o_arms, r_o_rew, r_o_sel};

endmodule

[rtl/ucbcs_ctrl.sv]
`include "ucb_bandit_channel_selector_top_assert.svh"

module ucbcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  ucbcs_pkg::t_sts i_sts,
    output ucbcs_pkg::t_cmd o_cmd
);
    import ucbcs_pkg::*;

    t_state            r_state, n_state;
    logic [ARM_W-1:0]  r_arm, n_arm;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_sts.warm ? ST_FINISH : ST_LN_INIT;
                end
            end
            ST_LN_INIT:  n_state = ST_LN_SQ;
            ST_LN_SQ: begin
                if (r_step == STEP_W'(LN_STEPS - 1)) begin
                    n_state = ST_LN_SCALE;
                end
            end
            ST_LN_SCALE: n_state = ST_DIV_W;
            ST_DIV_W:    n_state = ST_WAIT_W;
            ST_WAIT_W: begin
                if (i_sts.div_done) begin
                    n_state = ST_DIV_L;
                end
            end
            ST_DIV_L:    n_state = ST_WAIT_L;
            ST_WAIT_L: begin
                if (i_sts.div_done) begin
                    n_state = ST_WAIT_SQ;
                end
            end
            ST_WAIT_SQ: begin
                if (i_sts.sqrt_done) begin
                    n_state = (r_arm == ARM_W'(NUM_ARMS - 1)) ? ST_SORT : ST_DIV_W;
                end
            end
            ST_SORT:     n_state = ST_MUL;
            ST_MUL: begin
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = ST_CHOOSE;
                end
            end
            ST_CHOOSE:   n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.arm  = r_arm;
        o_cmd.step = r_step;
        o_s_tready = 1'b0;
        n_arm      = r_arm;
        n_step     = r_step;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            ST_LN_INIT: begin
                o_cmd.op = OP_LN_INIT;
                n_step   = '0;
            end
            ST_LN_SQ: begin
                o_cmd.op = OP_LN_SQ;
                n_step   = r_step + 1'b1;
            end
            ST_LN_SCALE: begin
                o_cmd.op = OP_LN_SCALE;
                n_arm    = '0;
            end
            ST_DIV_W: o_cmd.op = OP_DIV_W;
            ST_WAIT_W: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_STORE_W;
                end
            end
            ST_DIV_L: o_cmd.op = OP_DIV_L;
            ST_WAIT_L: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_SQRT;
                end
            end
            ST_WAIT_SQ: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.op = OP_STORE_IDX;
                    n_arm    = r_arm + 1'b1;
                end
            end
            ST_SORT: begin
                o_cmd.op = OP_SORT;
                n_step   = '0;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_step   = r_step + 1'b1;
            end
            ST_CHOOSE: o_cmd.op = OP_CHOOSE;
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.op = OP_FINISH;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
        if (o_cmd.op == OP_FINISH) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_arm       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_arm       <= n_arm;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `UCBCS_ASSERT_NXT(a_leave_idle, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state != ST_IDLE, "request accepted but controller stayed idle")
    `UCBCS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.op == OP_FINISH, !r_out_valid || i_m_tready, "result overwritten before it was taken")
    `UCBCS_ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n, i_sts.div_done, r_state == ST_WAIT_W || r_state == ST_WAIT_L, "divider finished outside a wait state")
    `UCBCS_ASSERT_IMP(a_sqrt_done_wait, i_clk, i_rst_n, i_sts.sqrt_done, r_state == ST_WAIT_SQ, "square root finished outside its wait state")

endmodule

[rtl/ucb_bandit_channel_selector_top.sv]
// Warm-up rounds go straight from the request to registering their result;
// other rounds run 20 log squarings, eight divisions,
// four square roots and nine products on one shared multiplier.
// Throughput: one request at a time; the next can be accepted in the cycle after the result is
// registered, while that result may still wait on the output.
// Reset: synchronous, active low; restores control state, configuration, arm counts and total at once.
module ucb_bandit_channel_selector_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ucbcs_pkg::IN_W-1:0]      s_axis_tdata,   // [15:0] random_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] selected_mask, [7:4] reward_mask, [10:8] arms_used, [13:11] round_reward,
    // [45:14] total_reward, [47:46] zero
    output logic [ucbcs_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ucbcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ucbcs_pkg::PROB_W-1:0]    i_cfg_data
);
    import ucbcs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ucbcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ucbcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tdata     (m_axis_tdata)
    );

endmodule
